// File: hdl/iqc_pkg.sv
// shared widths and status codes for the iq imbalance coefficient block
`default_nettype none

package iqc_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned WIDE_W   = 64;
    localparam int unsigned STATUS_W = 2;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_DET_BAD  = 2'd1;
    localparam status_t STATUS_ROOT_ZERO = 2'd2;

    localparam logic [DATA_W-1:0] SAT_MAG = 32'h7FFF_FFFF;

endpackage

`default_nettype wire

// File: hdl/iqc_mul.sv
// registered signed 32 by 32 multiplier for the determinant products
`default_nettype none

module iqc_mul (
    input  wire logic                                clk,
    input  wire logic signed [iqc_pkg::DATA_W-1:0]   a,
    input  wire logic signed [iqc_pkg::DATA_W-1:0]   b,
    output logic signed      [iqc_pkg::WIDE_W-1:0]   prod
);

    logic signed [iqc_pkg::WIDE_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: hdl/iqc_sub.sv
// shared 64-bit subtract and compare unit for determinant, root and division steps
`default_nettype none

module iqc_sub (
    input  wire logic [iqc_pkg::WIDE_W-1:0] a,
    input  wire logic [iqc_pkg::WIDE_W-1:0] b,
    output logic      [iqc_pkg::WIDE_W-1:0] diff,
    output logic                            ge
);

    logic [iqc_pkg::WIDE_W:0] full;

    always_comb
    begin
        full = {1'b0, a} - {1'b0, b};
        diff = full[iqc_pkg::WIDE_W-1:0];
        ge   = ~full[iqc_pkg::WIDE_W];
    end

endmodule

`default_nettype wire

// File: hdl/iq_imbalance_coeffs_q31.sv
// iq imbalance correction coefficients in q31, sequenced over one shared subtractor
// a new input is taken only in the idle state, so each item finishes before the next is
// accepted; when the determinant is not positive, the root and division steps are skipped
// the shared subtract and compare unit does 32 root steps, then 31 steps
// for each of the two divisions, after the two multiplier products
// rst_n clears the sequencer and output valid asynchronously; no other register is reset
`default_nettype none

module iq_imbalance_coeffs_q31 (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [iqc_pkg::DATA_W-1:0]     ii_sum,
    input  wire logic signed [iqc_pkg::DATA_W-1:0]     iq_sum,
    input  wire logic signed [iqc_pkg::DATA_W-1:0]     qq_sum,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed      [iqc_pkg::DATA_W-1:0]     gain_correction,
    output logic signed      [iqc_pkg::DATA_W-1:0]     phase_correction,
    output logic             [iqc_pkg::STATUS_W-1:0]   status
);

    localparam int unsigned DW      = iqc_pkg::DATA_W;
    localparam int unsigned WW      = iqc_pkg::WIDE_W;
    localparam int unsigned CNT_W   = 5;
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(DW - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DW - 2);
    localparam logic [WW-1:0] PROBE_INIT = {2'b01, {(WW-2){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_DET,
        S_ROOT,
        S_ROOT_CHK,
        S_DIV_INIT,
        S_DIV,
        S_FIN
    } state_t;

    state_t state_reg;

    logic signed [DW-1:0] ii_reg;
    logic signed [DW-1:0] iq_reg;
    logic signed [DW-1:0] qq_reg;
    logic [WW-1:0]        x_reg;
    logic [WW-1:0]        acc_reg;
    logic [WW-1:0]        probe_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DW-1:0]        root_reg;
    logic [DW-1:0]        rem_reg;
    logic [DW-2:0]        quo_reg;
    logic                 sat_reg;
    logic                 neg_reg;
    logic                 phase_sel_reg;
    logic [DW-1:0]        gain_res_reg;
    logic [DW-1:0]        phase_res_reg;
    iqc_pkg::status_t     status_res_reg;

    logic                 out_valid_reg;
    logic [DW-1:0]        gain_out_reg;
    logic [DW-1:0]        phase_out_reg;
    iqc_pkg::status_t     status_out_reg;

    logic signed [DW-1:0] mul_a;
    logic signed [DW-1:0] mul_b;
    logic signed [WW-1:0] prod;
    logic [WW-1:0]        sub_a;
    logic [WW-1:0]        sub_b;
    logic [WW-1:0]        sub_diff;
    logic                 sub_ge;

    logic [DW-1:0]        ii_mag;
    logic [DW-1:0]        iq_mag;
    logic                 iq_pos;
    logic [DW-1:0]        mag_sel;
    logic [DW-2:0]        quo_next;
    logic [DW-1:0]        qmag;
    logic [DW-1:0]        qval;
    logic                 det_bad;

    iqc_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    iqc_sub u_sub (
        .a    (sub_a),
        .b    (sub_b),
        .diff (sub_diff),
        .ge   (sub_ge)
    );

    always_comb
    begin
        ii_mag   = ii_reg[DW-1] ? (DW'(0) - ii_reg) : ii_reg;
        iq_mag   = iq_reg[DW-1] ? (DW'(0) - iq_reg) : iq_reg;
        iq_pos   = ~iq_reg[DW-1] && (iq_reg != '0);
        mag_sel  = phase_sel_reg ? iq_mag : ii_mag;
        quo_next = {quo_reg[DW-3:0], sub_ge};
        qmag     = sat_reg ? iqc_pkg::SAT_MAG : {1'b0, quo_next};
        qval     = neg_reg ? (DW'(0) - qmag) : qmag;
        det_bad  = sub_diff[WW-1] || (sub_diff == '0);
    end

    always_comb
    begin
        mul_a = qq_reg;
        mul_b = ii_reg;
        if (state_reg == S_MUL_B)
        begin
            mul_a = iq_reg;
            mul_b = iq_reg;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_DET:
            begin
                sub_a = x_reg;
                sub_b = prod;
            end
            S_ROOT:
            begin
                sub_a = x_reg;
                sub_b = acc_reg | probe_reg;
            end
            S_DIV_INIT:
            begin
                sub_a = {{(WW-DW){1'b0}}, mag_sel};
                sub_b = {{(WW-DW){1'b0}}, root_reg};
            end
            S_DIV:
            begin
                sub_a = {{(WW-DW-1){1'b0}}, rem_reg, 1'b0};
                sub_b = {{(WW-DW){1'b0}}, root_reg};
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= ((state_reg == S_FIN) && (!out_valid_reg || !out_stall))
                             || (out_valid_reg && out_stall);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_MUL_A;
                    end
                end
                S_MUL_A:
                begin
                    state_reg <= S_MUL_B;
                end
                S_MUL_B:
                begin
                    state_reg <= S_DET;
                end
                S_DET:
                begin
                    if (det_bad)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    if (cnt_reg == ROOT_LAST)
                    begin
                        state_reg <= S_ROOT_CHK;
                    end
                end
                S_ROOT_CHK:
                begin
                    if (acc_reg == '0)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_DIV_INIT;
                    end
                end
                S_DIV_INIT:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (cnt_reg == DIV_LAST)
                    begin
                        if (phase_sel_reg)
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_DIV_INIT;
                        end
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                ii_reg        <= ii_sum;
                iq_reg        <= iq_sum;
                qq_reg        <= qq_sum;
                phase_sel_reg <= 1'b0;
            end
            S_MUL_B:
            begin
                x_reg <= prod;
            end
            S_DET:
            begin
                x_reg          <= sub_diff;
                acc_reg        <= '0;
                probe_reg      <= PROBE_INIT;
                cnt_reg        <= '0;
                gain_res_reg   <= '0;
                phase_res_reg  <= '0;
                status_res_reg <= det_bad ? iqc_pkg::STATUS_DET_BAD : iqc_pkg::STATUS_OK;
            end
            S_ROOT:
            begin
                if (sub_ge)
                begin
                    x_reg   <= sub_diff;
                    acc_reg <= (acc_reg >> 1) + probe_reg;
                end
                else
                begin
                    acc_reg <= acc_reg >> 1;
                end
                probe_reg <= probe_reg >> 2;
                cnt_reg   <= cnt_reg + CNT_W'(1);
            end
            S_ROOT_CHK:
            begin
                root_reg <= acc_reg[DW-1:0];
                if (acc_reg == '0)
                begin
                    status_res_reg <= iqc_pkg::STATUS_ROOT_ZERO;
                end
            end
            S_DIV_INIT:
            begin
                sat_reg <= sub_ge;
                rem_reg <= mag_sel;
                neg_reg <= phase_sel_reg ? iq_pos : ii_reg[DW-1];
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            S_DIV:
            begin
                if (sub_ge)
                begin
                    rem_reg <= sub_diff[DW-1:0];
                end
                else
                begin
                    rem_reg <= {rem_reg[DW-2:0], 1'b0};
                end
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    if (phase_sel_reg)
                    begin
                        phase_res_reg <= qval;
                    end
                    else
                    begin
                        gain_res_reg  <= qval;
                        phase_sel_reg <= 1'b1;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    gain_out_reg   <= gain_res_reg;
                    phase_out_reg  <= phase_res_reg;
                    status_out_reg <= status_res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = out_valid_reg;
    assign gain_correction  = gain_out_reg;
    assign phase_correction = phase_out_reg;
    assign status           = status_out_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != iqc_pkg::STATUS_OK))
            |-> ((gain_correction == '0) && (phase_correction == '0)))
        else $error("error status with nonzero coefficients");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status == iqc_pkg::STATUS_OK) || (status == iqc_pkg::STATUS_DET_BAD)
            || (status == iqc_pkg::STATUS_ROOT_ZERO)))
        else $error("undefined status code");

    a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((gain_correction != {1'b1, {(DW-1){1'b0}}})
            && (phase_correction != {1'b1, {(DW-1){1'b0}}})))
        else $error("coefficient outside saturated range");

    a_fin_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_FIN))
        else $error("result raised outside final state");

endmodule

`default_nettype wire
